[sv/pill_counter_with_level_lock_assert.svh]
// assertion macros used by the controller rtl file
`ifndef PILL_COUNTER_WITH_LEVEL_LOCK_ASSERT_SVH
`define PILL_COUNTER_WITH_LEVEL_LOCK_ASSERT_SVH

`ifndef SYNTHESIS
`define PCLL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define PCLL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PCLL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define PCLL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[sv/pcll_pkg.sv]
package pcll_pkg;

    localparam int DEF_COUNT_MAX = 999;
    localparam int DEF_TIME_BITS = 32;

    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int PCT_W      = 7;
    localparam int RAW_W      = 10;
    localparam int ECHO_W     = 15;
    localparam int TGT_W      = 10;
    localparam int NOW_W      = 32;
    localparam int RUN_W      = 4;
    localparam int IN_TDATA_W = 104;
    localparam int IN_TUSER_W = 2;

    localparam logic [1:0] CMD_SAMPLE     = 2'd0;
    localparam logic [1:0] CMD_SET_TARGET = 2'd1;
    localparam logic [1:0] CMD_RESET_CNT  = 2'd2;
    localparam logic [1:0] CMD_OTHER      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PCT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_PCT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_NEEDED  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STATUS_PER  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COMM_TMO    = 3'd6;

    localparam logic [6:0]  RST_HIGH_PCT   = 7'd80;
    localparam logic [6:0]  RST_LOW_PCT    = 7'd75;
    localparam logic [3:0]  RST_RUN_NEEDED = 4'd10;
    localparam logic [14:0] RST_NEAR_LIMIT = 15'd588;
    localparam logic [15:0] RST_LOCKOUT    = 16'd150;
    localparam logic [15:0] RST_STATUS_PER = 16'd200;
    localparam logic [19:0] RST_COMM_TMO   = 20'd30000;

    localparam logic [TGT_W-1:0] TARGET_MAX  = 10'd999;
    localparam logic [TGT_W-1:0] WATER_DIV   = 10'd1023;
    localparam logic [PCT_W-1:0] PCT_FULL    = 7'd100;

    typedef struct packed {
        logic latch;
        logic div_load_prog;
        logic div_step;
        logic water_wr;
        logic eval;
        logic prog_wr;
        logic out_load;
    } pcll_ctrl_t;

    typedef struct packed {
        logic is_sample;
        logic div_done;
        logic need_prog;
        logic out_free;
    } pcll_stat_t;

endpackage

[sv/pill_counter_with_level_lock.sv]
// steps per item: latch, water percent (samples only), evaluate and output load; when the
// progress percent is recomputed, a bit-serial divide of count bits + 7 = 17 quotient bits
// at default comes before the output load, which waits while the previous result still waits
// there. flow: one item at a time, the next is taken only after the result is loaded; the
// bit-serial progress divider makes one quotient bit a cycle
// reset: synchronous active-low aresetn clears most state and loads default register values
module pill_counter_with_level_lock
    import pcll_pkg::*;
#(
    parameter int COUNT_MAX = DEF_COUNT_MAX,
    parameter int TIME_BITS = DEF_TIME_BITS,
    localparam int CNT_W    = $clog2(COUNT_MAX + 1),
    localparam int OUT_W    = ((CNT_W + 2 * PCT_W + 5 + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // now_ms, water_raw, echo_first, echo_second, echo_third, target_value, zero pad
    input  logic [IN_TDATA_W-1:0] s_tdata,
    // cmd
    input  logic [IN_TUSER_W-1:0] s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // item_count, progress_pct, water_pct, level_locked, high_alert, counted_now,
    // status_due, comm_lost, zero pad
    output logic [OUT_W-1:0]      m_tdata
);

    pcll_ctrl_t ctrl;
    pcll_stat_t stat;

    pcll_datapath #(
        .COUNT_MAX (COUNT_MAX),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    pcll_controller u_controller (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

endmodule

[sv/pcll_datapath.sv]
module pcll_datapath
    import pcll_pkg::*;
#(
    parameter int COUNT_MAX = DEF_COUNT_MAX,
    parameter int TIME_BITS = DEF_TIME_BITS,
    localparam int CNT_W    = $clog2(COUNT_MAX + 1),
    localparam int OUT_W    = ((CNT_W + 2 * PCT_W + 5 + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic [IN_TUSER_W-1:0] s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,
    input  pcll_ctrl_t            ctrl,
    output pcll_stat_t            stat
);

    localparam int PROD_W  = CNT_W + PCT_W;
    localparam int DVD_W   = PROD_W;
    localparam int DCNT_W  = $clog2(DVD_W + 1);
    localparam int CMP_W   = TIME_BITS > CFG_DATA_W ? TIME_BITS : CFG_DATA_W;
    localparam int WPROD_W = RAW_W + PCT_W;

    // configuration
    logic [PCT_W-1:0]      high_pct_reg, low_pct_reg;
    logic [RUN_W-1:0]      run_needed_reg;
    logic [ECHO_W-1:0]     near_limit_reg;
    logic [15:0]           lockout_reg, status_per_reg;
    logic [CFG_DATA_W-1:0] comm_tmo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_pct_reg   <= RST_HIGH_PCT;
            low_pct_reg    <= RST_LOW_PCT;
            run_needed_reg <= RST_RUN_NEEDED;
            near_limit_reg <= RST_NEAR_LIMIT;
            lockout_reg    <= RST_LOCKOUT;
            status_per_reg <= RST_STATUS_PER;
            comm_tmo_reg   <= RST_COMM_TMO;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_HIGH_PCT:   high_pct_reg   <= cfg_data[PCT_W-1:0];
                CFG_LOW_PCT:    low_pct_reg    <= cfg_data[PCT_W-1:0];
                CFG_RUN_NEEDED: run_needed_reg <= cfg_data[RUN_W-1:0];
                CFG_NEAR_LIMIT: near_limit_reg <= cfg_data[ECHO_W-1:0];
                CFG_LOCKOUT:    lockout_reg    <= cfg_data[15:0];
                CFG_STATUS_PER: status_per_reg <= cfg_data[15:0];
                CFG_COMM_TMO:   comm_tmo_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // latched item
    logic [1:0]        cmd_reg;
    logic [NOW_W-1:0]  now_reg;
    logic [RAW_W-1:0]  raw_reg;
    logic [ECHO_W-1:0] e1_reg, e2_reg, e3_reg;
    logic [TGT_W-1:0]  tv_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.latch) begin
            cmd_reg <= s_tuser;
            now_reg <= s_tdata[31:0];
            raw_reg <= s_tdata[41:32];
            e1_reg  <= s_tdata[56:42];
            e2_reg  <= s_tdata[71:57];
            e3_reg  <= s_tdata[86:72];
            tv_reg  <= s_tdata[96:87];
        end
    end

    // block state
    logic [RUN_W-1:0]     high_run_reg;
    logic                 lock_reg, alert_sent_reg, known_reg, tmo_reg;
    logic [TGT_W-1:0]     target_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [PCT_W-1:0]     prog_reg, water_reg;
    logic [TIME_BITS-1:0] lockout_end_reg, last_status_reg, last_serial_reg;
    logic                 alert_reg, counted_reg, due_reg;

    // water percent: divide by 1023 as 1024 - 1, high bits then one correction
    logic [WPROD_W-1:0] water_prod;
    logic [PCT_W-1:0]   water_q0, water_pct;
    logic [RAW_W:0]     water_rem;

    assign water_prod = WPROD_W'(raw_reg) * WPROD_W'(PCT_FULL);
    assign water_q0   = water_prod[WPROD_W-1:RAW_W];
    assign water_rem  = {1'b0, water_prod[RAW_W-1:0]} + (RAW_W+1)'(water_q0);
    assign water_pct  = water_q0 + PCT_W'(water_rem >= {1'b0, WATER_DIV});

    // bit-serial restoring divider
    logic [TGT_W-1:0]  rem_reg, dvs_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [TGT_W:0]    rem_shift;
    logic              rem_ge;

    assign rem_shift = {rem_reg, quo_reg[DVD_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else if (ctrl.div_load_prog) begin
            dcnt_reg <= DCNT_W'(DVD_W);
        end else if (ctrl.div_step && dcnt_reg != '0) begin
            dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.div_load_prog) begin
            rem_reg <= '0;
            quo_reg <= DVD_W'(count_reg) * DVD_W'(PCT_FULL);
            dvs_reg <= target_reg;
        end else if (ctrl.div_step && dcnt_reg != '0) begin
            rem_reg <= rem_ge ? TGT_W'(rem_shift - {1'b0, dvs_reg}) : rem_shift[TGT_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], rem_ge};
        end
    end

    // step evaluation
    logic                 is_sample, is_set, is_reset;
    logic                 tgt_ok, known_next;
    logic [TGT_W-1:0]     target_next;
    logic [TIME_BITS-1:0] now_t, serial_next, silence, since_status;
    logic                 tmo_hit, due_next;
    logic                 is_high, is_low, lock_next, alert_next, alert_sent_next;
    logic [RUN_W-1:0]     run_inc, run_next;
    logic                 near_all, counted_next;
    logic [CNT_W-1:0]     count_next;
    logic [PCT_W-1:0]     prog_next;

    always_comb begin
        is_sample   = cmd_reg == CMD_SAMPLE;
        is_set      = cmd_reg == CMD_SET_TARGET;
        is_reset    = cmd_reg == CMD_RESET_CNT;
        tgt_ok      = is_set && tv_reg <= TARGET_MAX;
        known_next  = known_reg || tgt_ok;
        target_next = tgt_ok ? tv_reg : target_reg;

        now_t        = TIME_BITS'(now_reg);
        serial_next  = is_sample ? last_serial_reg : now_t;
        silence      = now_t - serial_next;
        tmo_hit      = CMP_W'(silence) > CMP_W'(comm_tmo_reg);
        since_status = now_t - last_status_reg;
        due_next     = known_next && since_status >= TIME_BITS'(status_per_reg);

        is_high         = water_reg >= high_pct_reg;
        is_low          = water_reg <= low_pct_reg;
        run_inc         = high_run_reg < run_needed_reg ? high_run_reg + 1'b1 : high_run_reg;
        run_next        = high_run_reg;
        lock_next       = lock_reg;
        alert_sent_next = alert_sent_reg;
        alert_next      = 1'b0;
        if (is_sample) begin
            if (is_high) begin
                run_next = run_inc;
                if (run_inc >= run_needed_reg) begin
                    lock_next       = 1'b1;
                    alert_sent_next = 1'b1;
                    alert_next      = !alert_sent_reg;
                end
            end else if (is_low) begin
                run_next        = '0;
                lock_next       = 1'b0;
                alert_sent_next = 1'b0;
            end
        end

        near_all = e1_reg != '0 && e1_reg <= near_limit_reg &&
                   e2_reg != '0 && e2_reg <= near_limit_reg &&
                   e3_reg != '0 && e3_reg <= near_limit_reg;
        counted_next = is_sample && !lock_next && known_reg && near_all &&
                       now_t > lockout_end_reg;

        count_next = count_reg;
        if (is_reset) begin
            count_next = '0;
        end else if (counted_next && count_reg < CNT_W'(COUNT_MAX)) begin
            count_next = count_reg + 1'b1;
        end

        prog_next = prog_reg;
        if (is_reset || ((counted_next || due_next) && target_next == '0)) begin
            prog_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_run_reg    <= '0;
            lock_reg        <= 1'b0;
            alert_sent_reg  <= 1'b0;
            known_reg       <= 1'b0;
            tmo_reg         <= 1'b0;
            target_reg      <= '0;
            count_reg       <= '0;
            prog_reg        <= '0;
            water_reg       <= '0;
            lockout_end_reg <= '0;
            last_status_reg <= '0;
            last_serial_reg <= '0;
        end else begin
            if (ctrl.water_wr) begin
                water_reg <= water_pct;
            end
            if (ctrl.prog_wr) begin
                prog_reg <= quo_reg > DVD_W'(PCT_FULL) ? PCT_FULL : quo_reg[PCT_W-1:0];
            end
            if (ctrl.eval) begin
                high_run_reg    <= run_next;
                lock_reg        <= lock_next;
                alert_sent_reg  <= alert_sent_next;
                known_reg       <= known_next;
                target_reg      <= target_next;
                count_reg       <= count_next;
                prog_reg        <= prog_next;
                last_serial_reg <= serial_next;
                if (tmo_hit) begin
                    tmo_reg <= 1'b1;
                end
                if (counted_next) begin
                    lockout_end_reg <= now_t + TIME_BITS'(lockout_reg);
                end
                if (due_next) begin
                    last_status_reg <= now_t;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.eval) begin
            alert_reg   <= alert_next;
            counted_reg <= counted_next;
            due_reg     <= due_next;
        end
    end

    // output register
    logic             m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            m_data_reg <= OUT_W'({tmo_reg, due_reg, counted_reg, alert_reg, lock_reg,
                                  water_reg, prog_reg, count_reg});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign stat.is_sample = is_sample;
    assign stat.div_done  = dcnt_reg == '0;
    assign stat.need_prog = (counted_next || due_next) && target_next != '0;
    assign stat.out_free  = !m_valid_reg || m_tready;

endmodule

[sv/pcll_controller.sv]
`include "pill_counter_with_level_lock_assert.svh"

module pcll_controller
    import pcll_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  pcll_stat_t stat,
    output pcll_ctrl_t ctrl
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_START  = 6'b000010,
        ST_EVAL   = 6'b000100,
        ST_PSTART = 6'b001000,
        ST_PDIV   = 6'b010000,
        ST_FIN    = 6'b100000
    } pcll_state_t;

    pcll_state_t state_reg, state_next;
    logic        accept;

    assign s_tready = state_reg == ST_IDLE;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ctrl.latch = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (stat.is_sample) begin
                    ctrl.water_wr = 1'b1;
                end
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                ctrl.eval  = 1'b1;
                state_next = stat.need_prog ? ST_PSTART : ST_FIN;
            end
            ST_PSTART: begin
                ctrl.div_load_prog = 1'b1;
                state_next         = ST_PDIV;
            end
            ST_PDIV: begin
                if (stat.div_done) begin
                    ctrl.prog_wr = 1'b1;
                    state_next   = ST_FIN;
                end else begin
                    ctrl.div_step = 1'b1;
                end
            end
            ST_FIN: begin
                if (stat.out_free) begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `PCLL_ASSERT_IMP(a_out_free, aclk, aresetn, ctrl.out_load, stat.out_free, "result overwritten")
    `PCLL_ASSERT_NXT(a_one_item, aclk, aresetn, accept, !s_tready, "second item taken")
    `PCLL_ASSERT_NXT(a_pdiv_fin, aclk, aresetn, state_reg == ST_PDIV && stat.div_done, state_reg == ST_FIN, "progress not finished")
    `PCLL_ASSERT_NXT(a_eval_fin, aclk, aresetn, state_reg == ST_EVAL && !stat.need_prog, state_reg == ST_FIN, "needless divide")

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import pcll_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
    localparam int STUCK_LIMIT = 6000;
    localparam int HOLD_CYCLES = 500;
    localparam int HOLD_AT_ITEM = 250;

    typedef struct packed {
        logic [6:0]  pad;
        logic [9:0]  target_value;
        logic [14:0] echo_third;
        logic [14:0] echo_second;
        logic [14:0] echo_first;
        logic [9:0]  water_raw;
        logic [31:0] now_ms;
    } pill_in_t;

    typedef struct packed {
        logic       comm_lost;
        logic       status_due;
        logic       counted_now;
        logic       high_alert;
        logic       level_locked;
        logic [6:0] water_pct;
        logic [6:0] progress_pct;
        logic [9:0] item_count;
    } pill_out_t;

    typedef struct packed {
        logic [1:0] cmd;
        pill_in_t   item;
        logic       typed;
        pill_out_t  want;
    } dir_row_t;

    typedef struct packed {
        int high;
        int low;
        int run;
        int near;
        int lockout;
        int period;
        int tmo;
        int items;
        bit sat;
        bit jumps;
    } cfg_phase_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic [IN_TUSER_W-1:0] s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;

    pill_counter_with_level_lock dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor configuration
    logic [6:0]  hi_mark     = RST_HIGH_PCT;
    logic [6:0]  lo_mark     = RST_LOW_PCT;
    logic [3:0]  run_need    = RST_RUN_NEEDED;
    logic [14:0] near_lim    = RST_NEAR_LIMIT;
    logic [15:0] lockout_len = RST_LOCKOUT;
    logic [15:0] period_len  = RST_STATUS_PER;
    logic [19:0] tmo_len     = RST_COMM_TMO;

    // predictor state
    logic [3:0]  run_len = '0;
    logic        locked = 1'b0;
    logic        alert_done = 1'b0;
    logic        tgt_known = 1'b0;
    logic        lost = 1'b0;
    logic [9:0]  tgt = '0;
    logic [9:0]  cnt = '0;
    logic [6:0]  prog = '0;
    logic [6:0]  water = '0;
    logic [31:0] lockout_until = '0;
    logic [31:0] status_stamp = '0;
    logic [31:0] serial_stamp = '0;

    pill_out_t expected_status_q[$];
    dir_row_t  dir_rows[$];
    cfg_phase_t phase_plan[8];

    int          error_count = 0;
    int          rx_count = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    bit          calm = 1'b0;
    int          stuck_cycles = 0;
    logic [31:0] clock_now = '0;
    int          regime = 0;
    int          regime_left = 0;

    function automatic logic [6:0] progress_now();
        int p;
        if (!tgt_known || tgt == 0) return '0;
        p = (int'(cnt) * 100) / int'(tgt);
        return (p > int'(PCT_FULL)) ? PCT_FULL : 7'(p);
    endfunction

    function automatic bit echo_near(logic [14:0] d);
        return d != 0 && d <= near_lim;
    endfunction

    task automatic set_pill_reg(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] val);
        case (idx)
            CFG_HIGH_PCT:   hi_mark = val[6:0];
            CFG_LOW_PCT:    lo_mark = val[6:0];
            CFG_RUN_NEEDED: run_need = val[3:0];
            CFG_NEAR_LIMIT: near_lim = val[14:0];
            CFG_LOCKOUT:    lockout_len = val[15:0];
            CFG_STATUS_PER: period_len = val[15:0];
            CFG_COMM_TMO:   tmo_len = val[19:0];
            default: ;
        endcase
    endtask

    task automatic advance_pill_model(input logic [1:0] cmd, input pill_in_t it,
                                      output pill_out_t r);
        logic [31:0] t;
        logic [31:0] silence;
        logic [31:0] since_status;
        r = '0;
        t = it.now_ms;
        if (cmd != CMD_SAMPLE) serial_stamp = t;
        if (cmd == CMD_SET_TARGET) begin
            if (it.target_value <= TARGET_MAX) begin
                tgt = it.target_value;
                tgt_known = 1'b1;
            end
        end else if (cmd == CMD_RESET_CNT) begin
            cnt = '0;
            prog = '0;
        end else if (cmd == CMD_SAMPLE) begin
            water = 7'((32'(it.water_raw) * 32'd100) / 32'd1023);
            if (water >= hi_mark) begin
                if (run_len < run_need) run_len = run_len + 1'b1;
                if (run_len >= run_need) begin
                    locked = 1'b1;
                    if (!alert_done) begin
                        alert_done = 1'b1;
                        r.high_alert = 1'b1;
                    end
                end
            end else if (water <= lo_mark) begin
                run_len = '0;
                locked = 1'b0;
                alert_done = 1'b0;
            end
            if (!locked && tgt_known && echo_near(it.echo_first) && echo_near(it.echo_second)
                && echo_near(it.echo_third) && t > lockout_until) begin
                if (int'(cnt) < DEF_COUNT_MAX) cnt = cnt + 1'b1;
                r.counted_now = 1'b1;
                lockout_until = t + 32'(lockout_len);
                prog = progress_now();
            end
        end
        silence = t - serial_stamp;
        if (silence > 32'(tmo_len)) lost = 1'b1;
        since_status = t - status_stamp;
        if (tgt_known && since_status >= 32'(period_len)) begin
            prog = progress_now();
            r.status_due = 1'b1;
            status_stamp = t;
        end
        r.item_count = cnt;
        r.progress_pct = prog;
        r.water_pct = water;
        r.level_locked = locked;
        r.comm_lost = lost;
    endtask

    function automatic string show_status(pill_out_t s);
        return $sformatf("cnt=%0d prog=%0d water=%0d lock=%b alert=%b counted=%b due=%b lost=%b",
                         s.item_count, s.progress_pct, s.water_pct, s.level_locked,
                         s.high_alert, s.counted_now, s.status_due, s.comm_lost);
    endfunction

    task automatic flag_error(input string what, input pill_out_t want, input pill_out_t got);
        error_count++;
        if (error_count <= 10) begin
            $display("%0t %s: expected %s", $realtime, what, show_status(want));
            $display("%0t %s: actual   %s", $realtime, what, show_status(got));
        end
    endtask

    task automatic check_status(input pill_out_t got);
        pill_out_t want;
        if (expected_status_q.size() == 0) begin
            flag_error("item with nothing pending", '0, got);
        end else begin
            want = expected_status_q.pop_front();
            if (got.item_count !== want.item_count || got.progress_pct !== want.progress_pct
                || got.water_pct !== want.water_pct || got.level_locked !== want.level_locked
                || got.high_alert !== want.high_alert || got.counted_now !== want.counted_now
                || got.status_due !== want.status_due || got.comm_lost !== want.comm_lost)
                flag_error("mismatch", want, got);
        end
    endtask

    // result side: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_status(pill_out_t'(m_tdata[$bits(pill_out_t)-1:0]));
                rx_count++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_count == HOLD_AT_ITEM && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 21);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic push_item(input logic [1:0] cmd, input pill_in_t it, input logic typed,
                             input pill_out_t typed_want);
        pill_out_t predicted;
        if (!calm && $urandom_range(99) < 21) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 40);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= it;
        do @(posedge aclk); while (!s_tready);
        advance_pill_model(cmd, it, predicted);
        expected_status_q.push_back(typed ? typed_want : predicted);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        set_pill_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic drain_results();
        while (expected_status_q.size() != 0) @(posedge aclk);
    endtask

    function automatic pill_in_t dir_item(logic [31:0] now, int raw, int e1, int e2, int e3,
                                          int target);
        pill_in_t it;
        it = '0;
        it.now_ms = now;
        it.water_raw = 10'(raw);
        it.echo_first = 15'(e1);
        it.echo_second = 15'(e2);
        it.echo_third = 15'(e3);
        it.target_value = 10'(target);
        return it;
    endfunction

    function automatic pill_out_t plain_status(int count, int pct, int wat, bit counted, bit due);
        pill_out_t s;
        s = '0;
        s.item_count = 10'(count);
        s.progress_pct = 7'(pct);
        s.water_pct = 7'(wat);
        s.counted_now = counted;
        s.status_due = due;
        return s;
    endfunction

    task automatic make_random_item(input bit sat, input bit jumps, input int n,
                                    output logic [1:0] cmd, output pill_in_t it);
        int unsigned roll;
        int unsigned pct;
        int unsigned raw;
        logic [14:0] e[3];
        it = '0;
        roll = $urandom_range(99);
        if (sat) cmd = (n == 0) ? CMD_SET_TARGET : CMD_SAMPLE;
        else if (roll < 78) cmd = CMD_SAMPLE;
        else if (roll < 86) cmd = CMD_SET_TARGET;
        else if (roll < 92) cmd = CMD_RESET_CNT;
        else cmd = CMD_OTHER;

        roll = $urandom_range(99);
        if (sat) clock_now += $urandom_range(40, 1);
        else if (jumps && cmd != CMD_SAMPLE && roll < 5) clock_now = $urandom;
        else if (jumps && cmd != CMD_SAMPLE && roll < 10)
            clock_now = 32'hFFFF_FFFF - $urandom_range(300, 0);
        else if (roll < 10) clock_now += 0;
        else if (roll < 15) clock_now += $urandom_range(2000, 200);
        else clock_now += $urandom_range(150, 1);
        it.now_ms = clock_now;

        // water level comes in runs of low, high or mixed readings
        if (regime_left == 0) begin
            regime = $urandom_range(2, 0);
            regime_left = $urandom_range(int'(run_need) + 4, 1);
        end
        regime_left--;
        if (sat || regime == 0) pct = $urandom_range(int'(lo_mark), 0);
        else if (regime == 1) pct = $urandom_range(100, int'(hi_mark));
        else pct = $urandom_range(100, 0);
        raw = (pct * 1023 + 99) / 100;
        if (raw > 1023) raw = 1023;
        if (!sat && $urandom_range(99) < 10) raw = $urandom_range(1023, 0);
        it.water_raw = 10'(raw);

        if (sat || $urandom_range(99) < 75) begin
            foreach (e[k]) e[k] = 15'($urandom_range(int'(near_lim), 1));
        end else begin
            foreach (e[k]) begin
                case ($urandom_range(3, 0))
                    0: e[k] = '0;
                    1: e[k] = (near_lim >= 15'd30000) ? 15'd0 : near_lim + 1'b1;
                    2: e[k] = 15'($urandom_range(int'(near_lim), 1));
                    default: e[k] = 15'($urandom_range(30000, 0));
                endcase
            end
        end
        it.echo_first = e[0];
        it.echo_second = e[1];
        it.echo_third = e[2];

        roll = $urandom_range(99);
        if (sat) it.target_value = 10'($urandom_range(999, 100));
        else if (roll < 50) it.target_value = 10'($urandom_range(40, 1));
        else if (roll < 65) it.target_value = '0;
        else if (roll < 80) it.target_value = 10'($urandom_range(1023, 1000));
        else it.target_value = 10'($urandom_range(999, 0));
    endtask

    initial begin
        logic [1:0] cmd;
        pill_in_t   it;
        cfg_phase_t ph;

        phase_plan[0] = '{80, 75, 10, 588, 150, 200, 1000000, 150, 1'b0, 1'b0};
        phase_plan[1] = '{100, 0, 15, 30000, 65535, 65535, 1000000, 120, 1'b0, 1'b0};
        phase_plan[2] = '{0, 100, 1, 1, 0, 1, 1000000, 120, 1'b0, 1'b0};
        phase_plan[3] = '{50, 50, 0, 300, 20, 0, 1000000, 120, 1'b0, 1'b0};
        phase_plan[4] = '{90, 60, 3, 30000, 0, 500, 1000000, 1020, 1'b1, 1'b0};
        phase_plan[5] = '{60, 40, 4, 1000, 100, 150, 1000000, 150, 1'b0, 1'b1};
        phase_plan[6] = '{85, 20, 15, 5000, 300, 1000, 30000, 120, 1'b0, 1'b1};
        phase_plan[7] = '{70, 65, 2, 588, 50, 0, 0, 100, 1'b0, 1'b1};

        // cmd, item, typed, expected
        dir_rows.push_back('{CMD_SAMPLE, dir_item(10, 0, 1, 1, 1, 0), 1'b1,
                             plain_status(0, 0, 0, 0, 0)});
        dir_rows.push_back('{CMD_SAMPLE, dir_item(20, 1023, 30000, 30000, 30000, 0), 1'b1,
                             plain_status(0, 0, 100, 0, 0)});
        dir_rows.push_back('{CMD_SET_TARGET, dir_item(30, 0, 0, 0, 0, 1023), 1'b1,
                             plain_status(0, 0, 100, 0, 0)});
        dir_rows.push_back('{CMD_SET_TARGET, dir_item(40, 0, 0, 0, 0, 0), 1'b1,
                             plain_status(0, 0, 100, 0, 0)});
        dir_rows.push_back('{CMD_SET_TARGET, dir_item(300, 0, 0, 0, 0, 999), 1'b1,
                             plain_status(0, 0, 100, 0, 1)});
        dir_rows.push_back('{CMD_SAMPLE, dir_item(400, 500, 1, 1, 1, 0), 1'b1,
                             plain_status(1, 0, 48, 1, 0)});
        dir_rows.push_back('{CMD_SAMPLE, dir_item(550, 500, 588, 588, 588, 0), 1'b0, '0});
        dir_rows.push_back('{CMD_SAMPLE, dir_item(551, 500, 588, 588, 588, 0), 1'b0, '0});
        dir_rows.push_back('{CMD_SAMPLE, dir_item(800, 767, 589, 1, 1, 0), 1'b0, '0});
        dir_rows.push_back('{CMD_SAMPLE, dir_item(900, 818, 1, 0, 1, 0), 1'b0, '0});
        dir_rows.push_back('{CMD_SET_TARGET, dir_item(950, 0, 0, 0, 0, 2), 1'b0, '0});
        dir_rows.push_back('{CMD_SAMPLE, dir_item(1200, 300, 100, 200, 300, 0), 1'b0, '0});
        dir_rows.push_back('{CMD_RESET_CNT, dir_item(1300, 1023, 5, 5, 5, 7), 1'b0, '0});
        dir_rows.push_back('{CMD_OTHER, dir_item(32'hFFFF_FF00, 1023, 9, 9, 9, 5), 1'b0, '0});
        dir_rows.push_back('{CMD_SAMPLE, dir_item(32'hFFFF_FFFF, 682, 42, 17, 300, 0), 1'b0,
                             '0});
        dir_rows.push_back('{CMD_SAMPLE, dir_item(0, 341, 7, 7, 7, 0), 1'b0, '0});
        dir_rows.push_back('{CMD_SAMPLE, dir_item(200, 100, 1, 588, 2, 0), 1'b0, '0});
        dir_rows.push_back('{CMD_OTHER, dir_item(210, 0, 0, 0, 0, 0), 1'b0, '0});

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            push_item(dir_rows[i].cmd, dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        s_tvalid <= 1'b0;
        drain_results();
        clock_now = 32'd210;

        foreach (phase_plan[p]) begin
            ph = phase_plan[p];
            cfg_write(CFG_HIGH_PCT, 20'(ph.high));
            cfg_write(CFG_LOW_PCT, 20'(ph.low));
            cfg_write(CFG_RUN_NEEDED, 20'(ph.run));
            cfg_write(CFG_NEAR_LIMIT, 20'(ph.near));
            cfg_write(CFG_LOCKOUT, 20'(ph.lockout));
            cfg_write(CFG_STATUS_PER, 20'(ph.period));
            cfg_write(CFG_COMM_TMO, 20'(ph.tmo));
            if (p == 3) cfg_write(CFG_SPARE_IDX, 20'($urandom));
            cfg_we <= 1'b0;
            for (int n = 0; n < ph.items; n++) begin
                calm = ph.sat && n < 400;
                make_random_item(ph.sat, ph.jumps, n, cmd, it);
                push_item(cmd, it, 1'b0, '0);
            end
            calm = 1'b0;
            s_tvalid <= 1'b0;
            drain_results();
        end

        repeat (64) @(posedge aclk);
        if (error_count == 0 && expected_status_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
